### src/itoar_pkg.sv
`default_nettype none

package itoar_pkg;

  // ASCII codes used when forming characters
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;

  // radix limits and the decimal base
  localparam logic [5:0] RADIX_MIN     = 6'd2;
  localparam logic [5:0] RADIX_MAX     = 6'd36;
  localparam logic [5:0] DEC_RADIX     = 6'd10;
  localparam logic [5:0] MAX_DEC_DIGIT = 6'd9;

  // which character a push writes into the digit store
  typedef enum logic [1:0] {
    PUSH_DIGIT,
    PUSH_ZERO,
    PUSH_SIGN
  } push_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      start_div;
    logic      div_step;
    logic      push;
    push_sel_t push_sel;
    logic      rd;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
    logic full;
    logic neg;
    logic cnt_zero;
    logic div_last;
    logic last;
  } dp_status_t;

endpackage

`default_nettype wire

### src/itoar_dp.sv
`default_nettype none

module itoar_dp #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [VALUE_BITS-1:0]  value,
  input  wire logic [5:0]             radix,
  input  wire itoar_pkg::dp_cmd_t     cmd,
  output itoar_pkg::dp_status_t       status,
  output logic [6:0]                  character,
  output logic                        last
);

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [6:0]            store [MAX_DIGITS];
  logic [VALUE_BITS-1:0] remaining;
  logic [5:0]            rem;
  logic [5:0]            base;
  logic                  neg;
  logic [CW-1:0]         cnt;
  logic [BW-1:0]         bitcnt;

  logic [5:0]            radix_sat;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] magnitude;
  logic [6:0]            trial;
  logic [6:0]            trial_sub;
  logic                  fits;
  logic [5:0]            rem_next;
  logic [6:0]            rem_ext;
  logic [6:0]            digit_chr;
  logic [6:0]            push_chr;
  logic                  can_push;
  logic [CW-1:0]         cnt_dec;

  // input conditioning: clamp the radix, take the decimal magnitude
  always_comb begin
    if (radix < itoar_pkg::RADIX_MIN) begin
      radix_sat = itoar_pkg::RADIX_MIN;
    end else if (radix > itoar_pkg::RADIX_MAX) begin
      radix_sat = itoar_pkg::RADIX_MAX;
    end else begin
      radix_sat = radix;
    end
  end

  assign in_neg    = (radix_sat == itoar_pkg::DEC_RADIX) && value[VALUE_BITS-1];
  assign magnitude = in_neg ? ({VALUE_BITS{1'b0}} - value) : value;

  // one restoring division step: a quotient bit per cycle
  assign trial     = {rem, remaining[VALUE_BITS-1]};
  assign fits      = trial >= {1'b0, base};
  assign trial_sub = trial - {1'b0, base};
  assign rem_next  = fits ? trial_sub[5:0] : trial[5:0];

  // remainder to ASCII
  assign rem_ext   = {1'b0, rem};
  assign digit_chr = (rem > itoar_pkg::MAX_DEC_DIGIT)
                   ? itoar_pkg::CHAR_A + rem_ext - {1'b0, itoar_pkg::DEC_RADIX}
                   : itoar_pkg::CHAR_ZERO + rem_ext;

  always_comb begin
    case (cmd.push_sel)
      itoar_pkg::PUSH_DIGIT: push_chr = digit_chr;
      itoar_pkg::PUSH_ZERO:  push_chr = itoar_pkg::CHAR_ZERO;
      itoar_pkg::PUSH_SIGN:  push_chr = itoar_pkg::CHAR_MINUS;
      default:               push_chr = itoar_pkg::CHAR_ZERO;
    endcase
  end

  assign can_push = cnt < CW'(MAX_DIGITS);
  assign cnt_dec  = cnt - 1'b1;

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      bitcnt <= '0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.push && can_push) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.rd) begin
        cnt <= cnt_dec;
      end
      if (cmd.start_div) begin
        bitcnt <= BW'(VALUE_BITS - 1);
      end else if (cmd.div_step) begin
        bitcnt <= bitcnt - 1'b1;
      end
    end
  end

  // working value, remainder and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (cmd.load) begin
      remaining <= magnitude;
    end else if (cmd.div_step) begin
      remaining <= {remaining[VALUE_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base <= radix_sat;
      neg  <= in_neg;
    end
    if (cmd.start_div) begin
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_next;
    end
    if (cmd.rd) begin
      character <= store[cnt_dec[AW-1:0]];
      last      <= (cnt == CW'(1));
    end
  end

  // digit store, filled least significant first
  always_ff @(posedge clk) begin
    if (cmd.push && can_push) begin
      store[cnt[AW-1:0]] <= push_chr;
    end
  end

  assign status.rem_zero = (remaining == '0);
  assign status.full     = !can_push;
  assign status.neg      = neg;
  assign status.cnt_zero = (cnt == '0);
  assign status.div_last = (bitcnt == '0);
  assign status.last     = last;

endmodule

`default_nettype wire

### src/itoar_ctrl.sv
`default_nettype none

module itoar_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire itoar_pkg::dp_status_t status,
  output itoar_pkg::dp_cmd_t         cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_PUSH,
    ST_READ,
    ST_SHOW
  } state_t;

  state_t state;
  state_t state_next;

  // commands and next state
  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.push_sel = itoar_pkg::PUSH_DIGIT;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.rem_zero || status.full) begin
          // conversion finished: lone zero, or append the sign
          if (status.cnt_zero) begin
            cmd.push     = 1'b1;
            cmd.push_sel = itoar_pkg::PUSH_ZERO;
          end else if (status.neg) begin
            cmd.push     = 1'b1;
            cmd.push_sel = itoar_pkg::PUSH_SIGN;
          end
          state_next = ST_READ;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) begin
          state_next = status.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and handshake flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= (state_next == ST_IDLE);
      out_valid <= (state_next == ST_SHOW);
    end
  end

endmodule

`default_nettype wire

### src/integer_to_ascii_radix_top.sv
// Integer to ASCII converter with selectable radix.
// Input channel (in_valid/in_ready) takes a value and a radix (2..36; lower
// codes act as 2, higher as 36). In base 10 the value is two's complement and
// a negative number gets a leading '-'; other bases read it unsigned.
// Output channel (out_valid/out_ready) gives one ASCII character per transfer,
// most significant first, with last set on the final one. Zero gives "0".
// Digits are produced by a shared restoring divider, one quotient bit per
// cycle; each digit passes through a check, the division steps and a push.
// The characters are then read from the digit store one at a time, each
// offered until out_ready takes it.
// One item is handled at a time: in_ready is high only when the previous
// item's last character has been transferred. A stalled receiver holds the
// character and last steady until taken. Synchronous reset returns to idle
// with in_ready high and out_valid low; the digit store is not cleared.
`default_nettype none

module integer_to_ascii_radix_top #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_DIGITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] value,
  input  wire logic [5:0]            radix,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [6:0]                 character,
  output logic                       last
);

  itoar_pkg::dp_cmd_t    cmd;
  itoar_pkg::dp_status_t status;

  itoar_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  itoar_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .radix     (radix),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (last)
  );

endmodule

`default_nettype wire

### src/itoar_checker.sv
`default_nettype none

module itoar_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] character,
  input wire logic       last
);

  // never ready for input while a character is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // an input transfer makes the block busy
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready still high after input transfer");

  // final character transfer frees the block at once
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> (in_ready && !out_valid))
    else $error("block not idle after final character");

  // more characters pending: stay busy
  a_busy_mid_string: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> !in_ready)
    else $error("block idle before final character");

  // stalled character holds
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(character) && $stable(last)))
    else $error("output changed while stalled");

endmodule

bind integer_to_ascii_radix_top itoar_checker u_itoar_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .character (character),
  .last      (last)
);

`default_nettype wire
